// File: rtl/core/rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit.
// Needs a clk and rst signal in the scope where a macro is used.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define RAU_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RAU_ASSERT_IMPLIES(label, ante, cons)
`define RAU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/rau_pkg.sv
// Shared types, constants and the microprogram for the rational arithmetic unit.
// No dependencies; used by every module of the block.
package rau_pkg;

  localparam int OPW  = 16;           // operand numerator width
  localparam int DW   = OPW - 1;      // operand denominator width
  localparam int PW   = 2 * OPW;      // signed cross product width
  localparam int MW   = PW - 1;       // magnitude width
  localparam int CNTW = $clog2(MW);
  localparam int RNW  = 32;
  localparam int RDW  = 31;
  localparam int PCW  = 4;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic signed [OPW-1:0] a_num;
    logic [DW-1:0]         a_den;
    logic signed [OPW-1:0] b_num;
    logic [DW-1:0]         b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [RNW-1:0] result_num;
    logic [RDW-1:0]        result_den;
    logic                  div_zero;
  } rau_out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_N_AN_BD,
    OP_N_AN_BN,
    OP_D_AD_BN,
    OP_D_AD_BD,
    OP_N_ADD,
    OP_N_SUB,
    OP_PREP,
    OP_TWOS,
    OP_GCD,
    OP_GCD_FIN,
    OP_DIV,
    OP_FINISH
  } uop_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_START,
    C_KIND_MUL,
    C_KIND_DIV,
    C_KIND_SUB,
    C_SPECIAL,
    C_BOTH_EVEN,
    C_GCD_BUSY,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t           op;
    cond_t          cond;
    logic [PCW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       special;
    logic       both_even;
    logic       gcd_busy;
    logic       div_busy;
  } dp_status_t;

  function automatic uword_t mk_uword(uop_t o, cond_t c, int t);
    mk_uword = '{op: o, cond: c, target: PCW'(t)};
  endfunction

  // Branch taken when cond is true, otherwise fall through to pc + 1.
  function automatic uword_t ucode(logic [PCW-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = mk_uword(OP_NOP,     C_NOT_START, 0);
      4'd1:  w = mk_uword(OP_N_AN_BD, C_KIND_MUL,  7);
      4'd2:  w = mk_uword(OP_D_AD_BN, C_KIND_DIV,  9);
      4'd3:  w = mk_uword(OP_NOP,     C_KIND_SUB,  5);
      4'd4:  w = mk_uword(OP_N_ADD,   C_ALWAYS,    6);
      4'd5:  w = mk_uword(OP_N_SUB,   C_NEXT,      0);
      4'd6:  w = mk_uword(OP_D_AD_BD, C_ALWAYS,    9);
      4'd7:  w = mk_uword(OP_N_AN_BN, C_NEXT,      0);
      4'd8:  w = mk_uword(OP_D_AD_BD, C_NEXT,      0);
      4'd9:  w = mk_uword(OP_PREP,    C_SPECIAL,   14);
      4'd10: w = mk_uword(OP_TWOS,    C_BOTH_EVEN, 10);
      4'd11: w = mk_uword(OP_GCD,     C_GCD_BUSY,  11);
      4'd12: w = mk_uword(OP_GCD_FIN, C_NEXT,      0);
      4'd13: w = mk_uword(OP_DIV,     C_DIV_BUSY,  13);
      4'd14: w = mk_uword(OP_NOP,     C_OUT_FULL,  14);
      4'd15: w = mk_uword(OP_FINISH,  C_ALWAYS,    0);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/rau_sequencer.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on rau_pkg.
module rau_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                out_full,
  input  rau_pkg::dp_status_t status,
  output rau_pkg::uword_t     uw,
  output logic                idle
);
  import rau_pkg::*;

  logic [PCW-1:0] pc;
  logic [PCW-1:0] pc_next;
  logic           taken;

  assign uw   = ucode(pc);
  assign idle = (pc == '0);

  always_comb begin
    case (uw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NOT_START: taken = !start;
      C_KIND_MUL:  taken = (status.kind == KIND_MUL);
      C_KIND_DIV:  taken = (status.kind == KIND_DIV);
      C_KIND_SUB:  taken = (status.kind == KIND_SUB);
      C_SPECIAL:   taken = status.special;
      C_BOTH_EVEN: taken = status.both_even;
      C_GCD_BUSY:  taken = status.gcd_busy;
      C_DIV_BUSY:  taken = status.div_busy;
      C_OUT_FULL:  taken = out_full;
      default:     taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc + PCW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/core/rau_datapath.sv
// Datapath: shared multiplier, numerator/denominator registers, binary GCD
// and a two-lane restoring divider. Driven by the control word; needs rau_pkg.
module rau_datapath (
  input  logic                clk,
  input  logic                start,
  input  rau_pkg::rau_in_t    operand,
  input  rau_pkg::uword_t     uw,
  output rau_pkg::dp_status_t status,
  output rau_pkg::rau_out_t   result_next
);
  import rau_pkg::*;

  rau_in_t              item;
  logic signed [PW-1:0] n;
  logic signed [PW-1:0] d;
  logic [MW-1:0]        nm;     // |n|, then quotient
  logic [MW-1:0]        dm;     // |d|, then quotient
  logic [MW-1:0]        rem_n;
  logic [MW-1:0]        rem_d;
  logic [MW-1:0]        u;
  logic [MW-1:0]        v;
  logic [MW-1:0]        g;
  logic [CNTW-1:0]      k;
  logic [CNTW-1:0]      cnt;
  logic                 neg;
  logic                 dz;
  logic                 nz;

  logic signed [OPW:0]     mul_a;
  logic signed [OPW:0]     mul_b;
  logic signed [2*OPW+1:0] mul_p;
  logic signed [OPW:0]     an_x;
  logic signed [OPW:0]     bn_x;
  logic signed [OPW:0]     ad_x;
  logic signed [OPW:0]     bd_x;

  logic [MW:0] sh_n;
  logic [MW:0] sh_d;
  logic [MW:0] diff_n;
  logic [MW:0] diff_d;
  logic        ge_n;
  logic        ge_d;
  logic        gcd_busy;

  logic signed [PW-1:0] q_s;
  logic signed [PW-1:0] num_s;

  assign an_x = {item.a_num[OPW-1], item.a_num};
  assign bn_x = {item.b_num[OPW-1], item.b_num};
  assign ad_x = {2'b00, item.a_den};
  assign bd_x = {2'b00, item.b_den};

  always_comb begin
    case (uw.op)
      OP_N_AN_BN: begin
        mul_a = an_x;
        mul_b = bn_x;
      end
      OP_D_AD_BN: begin
        mul_a = ad_x;
        mul_b = bn_x;
      end
      OP_D_AD_BD: begin
        mul_a = ad_x;
        mul_b = bd_x;
      end
      default: begin
        mul_a = an_x;
        mul_b = bd_x;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One restoring step per lane; both lanes share the divisor g.
  assign sh_n   = {rem_n, nm[MW-1]};
  assign sh_d   = {rem_d, dm[MW-1]};
  assign diff_n = sh_n - {1'b0, g};
  assign diff_d = sh_d - {1'b0, g};
  assign ge_n   = (sh_n >= {1'b0, g});
  assign ge_d   = (sh_d >= {1'b0, g});

  assign gcd_busy = (u != '0) && (v != '0);

  assign status.kind      = item.kind;
  assign status.special   = (n == '0) || (d == '0);
  assign status.both_even = !u[0] && !v[0];
  assign status.gcd_busy  = gcd_busy;
  assign status.div_busy  = (cnt != CNTW'(MW - 1));

  always_ff @(posedge clk) begin
    if (start) begin
      item <= operand;
    end
    unique case (uw.op)
      OP_NOP, OP_FINISH: begin
      end
      OP_N_AN_BD, OP_N_AN_BN: n <= PW'(mul_p);
      OP_D_AD_BN, OP_D_AD_BD: d <= PW'(mul_p);
      OP_N_ADD:   n <= n + d;
      OP_N_SUB:   n <= n - d;
      OP_PREP: begin
        nm  <= n[PW-1] ? MW'(-n) : MW'(n);
        dm  <= d[PW-1] ? MW'(-d) : MW'(d);
        u   <= n[PW-1] ? MW'(-n) : MW'(n);
        v   <= d[PW-1] ? MW'(-d) : MW'(d);
        neg <= n[PW-1] ^ d[PW-1];
        dz  <= (d == '0);
        nz  <= (n == '0);
        k   <= '0;
      end
      OP_TWOS: begin
        if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + CNTW'(1);
        end
      end
      OP_GCD: begin
        // Stein step: at most one operand is even here
        if (gcd_busy) begin
          if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
      end
      OP_GCD_FIN: begin
        g     <= (u | v) << k;
        rem_n <= '0;
        rem_d <= '0;
        cnt   <= '0;
      end
      OP_DIV: begin
        rem_n <= ge_n ? diff_n[MW-1:0] : sh_n[MW-1:0];
        rem_d <= ge_d ? diff_d[MW-1:0] : sh_d[MW-1:0];
        nm    <= {nm[MW-2:0], ge_n};
        dm    <= {dm[MW-2:0], ge_d};
        cnt   <= cnt + CNTW'(1);
      end
      default: begin
      end
    endcase
  end

  assign q_s   = $signed({1'b0, nm});
  assign num_s = neg ? -q_s : q_s;

  always_comb begin
    if (dz) begin
      result_next.result_num = '0;
      result_next.result_den = '0;
      result_next.div_zero   = 1'b1;
    end else if (nz) begin
      result_next.result_num = '0;
      result_next.result_den = RDW'(1);
      result_next.div_zero   = 1'b0;
    end else begin
      result_next.result_num = RNW'(num_s);
      result_next.result_den = RDW'(dm);
      result_next.div_zero   = 1'b0;
    end
  end

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit, top level: handshake, output register, assertions.
// Instantiates rau_sequencer and rau_datapath; needs rau_pkg and the defines header.
//
// Operand channel (operand_valid/operand_ready/operand) takes one beat: an
// operation code and two fractions. Result channel (result_valid/result_ready/
// result) returns one beat per operand: the reduced fraction with a positive
// denominator, 0/1 for a zero numerator, or 0/0 with div_zero set when the
// denominator would be zero.
// One item is in work at a time; operand_ready is high while the sequencer
// sits at its idle step. The sequencer forms the cross products and, unless a
// part is zero, removes the common factors of two, runs the binary GCD steps,
// one per cycle, and runs the bit-serial two-lane divider that scales both
// parts by the GCD. The next operand is taken once the sequencer is back at
// idle after the result loads.
// The finished result sits in the output register; the next operand beat is
// accepted while it waits. If the receiver stalls, the sequencer holds at its
// wait step just before the load until the output register frees.
// Reset (rst, synchronous) returns the sequencer to idle and drops result_valid.
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_ready,
  input  rau_pkg::rau_in_t  operand,
  output logic              result_valid,
  input  logic              result_ready,
  output rau_pkg::rau_out_t result
);
  import rau_pkg::*;

  `include "rational_arithmetic_unit_defines.svh"

  uword_t     uw;
  dp_status_t status;
  rau_out_t   result_next;
  logic       idle;
  logic       start;
  logic       out_full;
  logic       load;

  assign operand_ready = idle;
  assign start         = operand_valid && idle;
  assign out_full      = result_valid && !result_ready;
  assign load          = (uw.op == OP_FINISH);

  rau_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_full (out_full),
    .status   (status),
    .uw       (uw),
    .idle     (idle)
  );

  rau_datapath u_dp (
    .clk         (clk),
    .start       (start),
    .operand     (operand),
    .uw          (uw),
    .status      (status),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      result <= result_next;
    end
  end

  `RAU_ASSERT_NEXT(a_busy_after_accept, operand_valid && operand_ready, !operand_ready)
  `RAU_ASSERT_IMPLIES(a_no_overwrite, load, !(result_valid && !result_ready))
  `RAU_ASSERT_IMPLIES(a_err_is_zero, result_valid && result.div_zero,
                      (result.result_num == '0) && (result.result_den == '0))
  `RAU_ASSERT_IMPLIES(a_den_nonzero, result_valid && !result.div_zero, result.result_den != '0)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for rational_arithmetic_unit: fraction add/sub/mul/div with reduction.
// Needs rau_pkg and the RTL; a queue-fed driver and a clocked monitor compare
// every result beat with a behavioral reduced-fraction predictor.
module tb_top;
  import rau_pkg::*;

  typedef struct {
    rau_in_t beat;
    bit      drain_first;  // wait until all results are back before offering this beat
  } job_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     operand_valid = 1'b0;
  logic     operand_ready;
  rau_in_t  operand = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  rau_out_t result;

  job_t        jobs_q[$];
  rau_out_t    fraction_q[$];
  int unsigned beats_in, beats_out;
  int unsigned send_gap, recv_gap;
  int unsigned hold_cnt, holds_done;
  int unsigned mismatches, kind_seen[4], zero_den_seen, zero_num_seen;

  rational_arithmetic_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .operand      (operand),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact cross products in 64 bits, Euclid reduction, sign moved to the numerator.
  function automatic rau_out_t reduce_fraction(rau_in_t op);
    longint an, ad, bn, bd, n, d;
    longint unsigned nm, dm, x, y, t, rn, rd;
    rau_out_t res;
    an = longint'(op.a_num);
    ad = longint'(op.a_den);
    bn = longint'(op.b_num);
    bd = longint'(op.b_den);
    case (op.kind)
      KIND_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      KIND_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      KIND_MUL: begin n = an * bn;           d = ad * bd; end
      default:  begin n = an * bd;           d = ad * bn; end
    endcase
    res = '0;
    if (d == 0) begin
      res.div_zero = 1'b1;
      return res;
    end
    if (n == 0) begin
      res.result_den = RDW'(1);
      return res;
    end
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    rn = nm / x;
    rd = dm / x;
    if ((n < 0) != (d < 0)) rn = -rn;
    res.result_num = rn[31:0];
    res.result_den = rd[30:0];
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; calm windows have none.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [OPW-1:0] pick_num();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: case ($urandom_range(0, 4))
           0: return -16'sd32768;
           1: return 16'sd32767;
           2: return 16'sd0;
           3: return 16'sd1;
           default: return -16'sd1;
         endcase
      1, 2: return OPW'($signed($urandom_range(0, 40)) - 20);
      default: return OPW'($urandom);
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_den();
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r == 0) return '0;  // zero denominator, outside the nominal range
    if (r < 12) return ($urandom_range(0, 1) != 0) ? DW'(32767) : DW'(1);
    if (r < 60) return DW'($urandom_range(1, 64));
    if (r < 80) return DW'(1) << $urandom_range(0, DW - 1);
    return DW'($urandom_range(1, 32767));
  endfunction

  task automatic add_job(logic [1:0] k, int an, int ad, int bn, int bd, bit drain);
    job_t j;
    j.beat.kind  = k;
    j.beat.a_num = OPW'(an);
    j.beat.a_den = DW'(ad);
    j.beat.b_num = OPW'(bn);
    j.beat.b_den = DW'(bd);
    j.drain_first = drain;
    jobs_q.push_back(j);
  endtask

  task automatic add_random_job(bit drain);
    job_t j;
    j.beat.kind  = 2'($urandom_range(0, 3));
    j.beat.a_num = pick_num();
    j.beat.a_den = pick_den();
    if ($urandom_range(0, 9) == 0) begin
      // same or negated operand: zero differences and sums, unit quotients
      j.beat.b_num = ($urandom_range(0, 1) != 0) ? j.beat.a_num : -j.beat.a_num;
      j.beat.b_den = j.beat.a_den;
    end else begin
      j.beat.b_num = ($urandom_range(0, 24) == 0) ? '0 : pick_num();
      j.beat.b_den = pick_den();
    end
    j.drain_first = drain;
    jobs_q.push_back(j);
  endtask

  // Driver: offers queued beats, holds payload until accepted.
  always @(posedge clk) begin
    logic fire;
    fire = operand_valid && operand_ready;
    if (rst) begin
      operand_valid <= 1'b0;
      send_gap      <= 0;
      beats_in      <= 0;
    end else begin
      if (fire) begin
        fraction_q.push_back(reduce_fraction(operand));
        kind_seen[operand.kind]++;
        beats_in <= beats_in + 1;
      end
      if (!operand_valid || fire) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          operand_valid <= 1'b0;
        end else if (jobs_q.size() != 0 &&
                     !(jobs_q[0].drain_first && (fire || beats_in != beats_out))) begin
          operand       <= jobs_q[0].beat;
          operand_valid <= 1'b1;
          send_gap      <= pick_gap(((beats_in / 150) % 5) == 2);
          void'(jobs_q.pop_front());
        end else begin
          operand_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, twice, so the unit backs up and drops operand_ready.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt   <= 0;
      holds_done <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if ((holds_done == 0 && beats_in >= 300) ||
                 (holds_done == 1 && beats_in >= 1000)) begin
      hold_cnt   <= 500;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    rau_out_t    want;
    int unsigned g;
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap     <= 0;
      beats_out    <= 0;
    end else begin
      if (result_valid && result_ready) begin
        beats_out <= beats_out + 1;
        if (fraction_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat num=%0d den=%0d dz=%0b",
                     result.result_num, result.result_den, result.div_zero);
        end else begin
          want = fraction_q.pop_front();
          if (want.div_zero) zero_den_seen++;
          else if (want.result_num == 0) zero_num_seen++;
          if (result.result_num !== want.result_num ||
              result.result_den !== want.result_den ||
              result.div_zero !== want.div_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: beat %0d exp %0d/%0d dz=%0b got %0d/%0d dz=%0b",
                       beats_out, want.result_num, want.result_den, want.div_zero,
                       result.result_num, result.result_den, result.div_zero);
          end
        end
      end
      if (hold_cnt != 0) begin
        result_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap     <= recv_gap - 1;
        result_ready <= (recv_gap == 1);
      end else if ((result_valid && result_ready) || $urandom_range(0, 19) == 0) begin
        g = pick_gap(((beats_out / 150) % 5) == 3);
        recv_gap     <= g;
        result_ready <= (g == 0);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    // extremes, every operation, zero and sign cases
    add_job(KIND_ADD, 1, 2, 1, 3, 1'b0);
    add_job(KIND_SUB, 1, 2, 1, 2, 1'b0);            // zero result -> 0/1
    add_job(KIND_MUL, 2, 3, 3, 4, 1'b0);
    add_job(KIND_DIV, 2, 3, 4, 9, 1'b0);
    add_job(KIND_DIV, 5, 7, 0, 3, 1'b0);            // divide by zero
    add_job(KIND_DIV, 5, 7, -3, 11, 1'b0);          // negative denominator flips
    add_job(KIND_DIV, -32768, 1, -1, 32767, 1'b0);
    add_job(KIND_MUL, -32768, 1, -32768, 1, 1'b0);
    add_job(KIND_ADD, -32768, 1, -32768, 1, 1'b0);
    add_job(KIND_SUB, -32768, 1, 32767, 1, 1'b0);
    add_job(KIND_ADD, 32767, 32767, 32767, 32767, 1'b0);
    add_job(KIND_SUB, 32767, 1, -32768, 32767, 1'b0);
    add_job(KIND_MUL, 32767, 32767, -32768, 32767, 1'b0);
    add_job(KIND_MUL, 0, 5, 7, 9, 1'b0);            // zero numerator
    add_job(KIND_ADD, 3, 0, 1, 4, 1'b0);            // zero left denominator
    add_job(KIND_MUL, 3, 5, 1, 0, 1'b0);            // zero right denominator
    add_job(KIND_DIV, 0, 5, 0, 5, 1'b0);            // 0/0 takes the error path
    add_job(KIND_DIV, 0, 5, 7, 3, 1'b0);
    add_job(KIND_ADD, 12345, 16384, -12345, 16384, 1'b0);
    add_job(KIND_DIV, 32767, 16384, -32768, 1, 1'b0);
    add_job(KIND_SUB, -1, 32767, -1, 32767, 1'b0);
    add_job(KIND_MUL, 21845, 10922, 10922, 21845, 1'b0);
    for (int i = 0; i < 1600; i++)
      add_random_job(i == 0 || i == 500 || i == 1200);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (jobs_q.size() != 0 || operand_valid);
    do @(posedge clk); while (beats_out != beats_in);
    repeat (150) @(posedge clk);
    if (fraction_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d predicted results never arrived", fraction_q.size());
    end

    $display("Ran %0d operand beats (add %0d, sub %0d, mul %0d, div %0d) with random stalls.",
             beats_in, kind_seen[KIND_ADD], kind_seen[KIND_SUB], kind_seen[KIND_MUL],
             kind_seen[KIND_DIV]);
    $display("Zero-denominator errors: %0d, zero numerators: %0d, mismatches: %0d",
             zero_den_seen, zero_num_seen, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10000000;
    $display("ERROR: timeout with %0d beats in, %0d out", beats_in, beats_out);
    $display("FAIL");
    $finish;
  end

endmodule
